FILE: src/assert_macros.svh
// Assertion helpers: sampled on clk_i, off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define WHP_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define WHP_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: src/whp_pkg.sv
package whp_pkg;

  typedef enum logic [2:0] {
    PH_RIFF_TAG  = 3'd0,
    PH_RIFF_SIZE = 3'd1,
    PH_WAVE_TAG  = 3'd2,
    PH_CHUNK_HDR = 3'd3,
    PH_FMT_BODY  = 3'd4,
    PH_SKIP      = 3'd5,
    PH_DONE      = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_TAG   = 3'd1,
    ST_FMT_SMALL = 3'd2,
    ST_NO_FMT    = 3'd3,
    ST_TRUNC     = 3'd4
  } status_e;

  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagFmt  = 32'h666D_7420;
  localparam logic [31:0] TagData = 32'h6461_7461;
  localparam logic [31:0] FmtMin  = 32'd16;

  // Minimum offset of the first data byte in a good file.
  localparam logic [31:0] MinDataOffset = 32'd44;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] channels;
    logic [31:0] samp_rate;
    logic [15:0] sample_bits;
    logic [31:0] payload_size;
    logic [31:0] payload_offset;
  } out_beat_t;

endpackage

FILE: src/whp_parse.sv
module whp_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  whp_pkg::in_beat_t  beat_i,
  output logic               res_valid_o,
  output whp_pkg::out_beat_t res_beat_o
);

  whp_pkg::phase_e phase_q, phase_d, b_phase;
  logic [31:0] pos_q, pos_d, b_pos;
  logic [3:0]  cnt_q, cnt_d, b_cnt;
  logic [31:0] tag_q, tag_d, b_tag;
  logic [31:0] size_q, size_d, b_size;
  logic [31:0] skip_q, skip_d, b_skip;
  logic        seen_q, seen_d, b_seen;
  logic [15:0] ch_q, ch_d, b_ch;
  logic [31:0] rate_q, rate_d, b_rate;
  logic [15:0] bits_q, bits_d, b_bits;
  logic        done_q, done_d, b_done;
  logic [7:0]  byte_v;
  logic        hit;
  whp_pkg::status_e st;

  assign byte_v = beat_i.data_byte;

  always_comb begin
    // restart on first, before anything else
    if (beat_i.first) begin
      b_phase = whp_pkg::PH_RIFF_TAG;
      b_pos   = '0;
      b_cnt   = '0;
      b_tag   = '0;
      b_size  = '0;
      b_skip  = '0;
      b_seen  = 1'b0;
      b_ch    = '0;
      b_rate  = '0;
      b_bits  = '0;
      b_done  = 1'b0;
    end else begin
      b_phase = phase_q;
      b_pos   = pos_q;
      b_cnt   = cnt_q;
      b_tag   = tag_q;
      b_size  = size_q;
      b_skip  = skip_q;
      b_seen  = seen_q;
      b_ch    = ch_q;
      b_rate  = rate_q;
      b_bits  = bits_q;
      b_done  = done_q;
    end
  end

  always_comb begin
    phase_d = b_phase;
    pos_d   = b_pos;
    cnt_d   = b_cnt;
    tag_d   = b_tag;
    size_d  = b_size;
    skip_d  = b_skip;
    seen_d  = b_seen;
    ch_d    = b_ch;
    rate_d  = b_rate;
    bits_d  = b_bits;
    done_d  = b_done;
    hit     = 1'b0;
    st      = whp_pkg::ST_OK;
    if (!b_done) begin
      if (b_pos != 32'hFFFF_FFFF) begin
        pos_d = b_pos + 32'd1;
      end
      cnt_d = b_cnt + 4'd1;
      unique case (b_phase)
        whp_pkg::PH_RIFF_TAG, whp_pkg::PH_WAVE_TAG: begin
          tag_d = {b_tag[23:0], byte_v};
          if (cnt_d == 4'd4) begin
            cnt_d = '0;
            if (tag_d != ((b_phase == whp_pkg::PH_RIFF_TAG) ? whp_pkg::TagRiff
                                                            : whp_pkg::TagWave)) begin
              hit = 1'b1;
              st  = whp_pkg::ST_BAD_TAG;
              cnt_d = 4'd4;
            end else if (b_phase == whp_pkg::PH_RIFF_TAG) begin
              phase_d = whp_pkg::PH_RIFF_SIZE;
            end else begin
              phase_d = whp_pkg::PH_CHUNK_HDR;
            end
          end
        end
        whp_pkg::PH_RIFF_SIZE: begin
          if (cnt_d == 4'd4) begin
            cnt_d   = '0;
            phase_d = whp_pkg::PH_WAVE_TAG;
          end
        end
        whp_pkg::PH_CHUNK_HDR: begin
          if (b_cnt < 4'd4) begin
            tag_d = {b_tag[23:0], byte_v};
          end else begin
            size_d = {byte_v, b_size[31:8]};
          end
          if (cnt_d == 4'd8) begin
            cnt_d = '0;
            if (tag_d == whp_pkg::TagFmt) begin
              if (size_d < whp_pkg::FmtMin) begin
                hit = 1'b1;
                st  = whp_pkg::ST_FMT_SMALL;
              end else begin
                phase_d = whp_pkg::PH_FMT_BODY;
              end
            end else if (tag_d == whp_pkg::TagData) begin
              hit = 1'b1;
              st  = b_seen ? whp_pkg::ST_OK : whp_pkg::ST_NO_FMT;
            end else if (size_d != '0) begin
              skip_d  = size_d;
              phase_d = whp_pkg::PH_SKIP;
            end
          end
        end
        whp_pkg::PH_FMT_BODY: begin
          unique case (b_cnt)
            4'd2:    ch_d = {8'h00, byte_v};
            4'd3:    ch_d = {b_ch[15:8] | byte_v, b_ch[7:0]};
            4'd4:    rate_d = {24'h0, byte_v};
            4'd5:    rate_d = {b_rate[31:16], b_rate[15:8] | byte_v, b_rate[7:0]};
            4'd6:    rate_d = {b_rate[31:24], b_rate[23:16] | byte_v, b_rate[15:0]};
            4'd7:    rate_d = {b_rate[31:24] | byte_v, b_rate[23:0]};
            4'd14:   bits_d = {8'h00, byte_v};
            4'd15:   bits_d = {b_bits[15:8] | byte_v, b_bits[7:0]};
            default: ;
          endcase
          if (cnt_d == 4'd0) begin
            seen_d = 1'b1;
            skip_d = b_size - whp_pkg::FmtMin;
            phase_d = (skip_d == '0) ? whp_pkg::PH_CHUNK_HDR : whp_pkg::PH_SKIP;
          end
        end
        whp_pkg::PH_SKIP: begin
          cnt_d = b_cnt;
          if (b_skip != '0) begin
            skip_d = b_skip - 32'd1;
          end
          if (skip_d == '0) begin
            phase_d = whp_pkg::PH_CHUNK_HDR;
            cnt_d   = '0;
          end
        end
        default: begin
          cnt_d = b_cnt;
        end
      endcase
      if (!hit && beat_i.last) begin
        hit = 1'b1;
        st  = whp_pkg::ST_TRUNC;
      end
      if (hit) begin
        done_d  = 1'b1;
        phase_d = whp_pkg::PH_DONE;
      end
    end
  end

  always_comb begin
    res_valid_o = step_i && hit;
    res_beat_o  = '0;
    res_beat_o.status = st;
    if (st == whp_pkg::ST_OK) begin
      res_beat_o.channels       = ch_d;
      res_beat_o.samp_rate      = rate_d;
      res_beat_o.sample_bits    = bits_d;
      res_beat_o.payload_size   = size_d;
      res_beat_o.payload_offset = pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= whp_pkg::PH_RIFF_TAG;
      pos_q   <= '0;
      cnt_q   <= '0;
      tag_q   <= '0;
      size_q  <= '0;
      skip_q  <= '0;
      seen_q  <= 1'b0;
      ch_q    <= '0;
      rate_q  <= '0;
      bits_q  <= '0;
      done_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      tag_q   <= tag_d;
      size_q  <= size_d;
      skip_q  <= skip_d;
      seen_q  <= seen_d;
      ch_q    <= ch_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
      done_q  <= done_d;
    end
  end

endmodule

FILE: src/wave_header_parser.sv
// Channel | Direction | Handshake              | Beat
// in      | input     | in_valid_i / in_ready_o  | whp_pkg::in_beat_t (one file byte)
// out     | output    | out_valid_o / out_ready_i | whp_pkg::out_beat_t (one per file)
//
// One byte per cycle sustained unless a waiting result stalls the output; a byte
// passes through the input register and its result, if any, lands in the output register.
// Reset clears the parse state, as if a first byte had been seen.
// A result left waiting in the output register holds the byte in the input
// register; up to one more byte is taken before in_ready_o drops.
module wave_header_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  whp_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output whp_pkg::out_beat_t out_beat_o
);

  logic               in_valid_q;
  whp_pkg::in_beat_t  in_beat_q;
  logic               out_valid_q;
  whp_pkg::out_beat_t out_beat_q;
  logic               adv;
  logic               res_valid;
  whp_pkg::out_beat_t res_beat;

  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  whp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv),
    .beat_i      (in_beat_q),
    .res_valid_o (res_valid),
    .res_beat_o  (res_beat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_beat_q <= in_beat_i;
    end
    if (adv && res_valid) begin
      out_beat_q <= res_beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

FILE: src/whp_checker.sv
`include "assert_macros.svh"

module whp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input whp_pkg::in_beat_t  in_beat_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input whp_pkg::out_beat_t out_beat_o
);

  logic err_beat;
  logic zero_fields;
  logic ok_beat;
  logic ofs_ok;
  logic out_stall;
  logic in_acc;
  logic quiet;

  assign err_beat    = out_valid_o && (out_beat_o.status != whp_pkg::ST_OK);
  assign zero_fields = (out_beat_o.channels == '0) && (out_beat_o.samp_rate == '0) &&
                       (out_beat_o.sample_bits == '0) && (out_beat_o.payload_size == '0) &&
                       (out_beat_o.payload_offset == '0);
  assign ok_beat     = out_valid_o && (out_beat_o.status == whp_pkg::ST_OK);
  assign ofs_ok      = out_beat_o.payload_offset >= whp_pkg::MinDataOffset;
  assign out_stall   = out_valid_o && !out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign quiet       = !out_valid_o && !in_valid_i && in_ready_o;

  `WHP_ASSERT_NXT(a_out_hold, out_stall, out_valid_o && $stable(out_beat_o), "out beat moved")
  `WHP_ASSERT_IMP(a_err_zero, err_beat, zero_fields, "error beat carries nonzero fields")
  `WHP_ASSERT_IMP(a_ok_offset, ok_beat, ofs_ok, "data offset too small")
  `WHP_ASSERT_NXT(a_no_early, quiet && !$past(in_acc), !out_valid_o, "result without a byte")

endmodule

bind wave_header_parser whp_checker u_whp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_beat_i   (in_beat_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_beat_o  (out_beat_o)
);

FILE: sim/wave_header_checker.sv
`timescale 1ns / 1ps

module wave_header_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  whp_pkg::in_beat_t  in_beat_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  whp_pkg::out_beat_t out_beat_i,
  output int                 errors_o,
  output int                 outstanding_o
);

  whp_pkg::phase_e ph;
  logic [31:0] pos;
  logic [3:0]  fcnt;
  logic [31:0] tag_sh;
  logic [31:0] size_sh;
  logic [31:0] skip_left;
  logic        fmt_found;
  logic [15:0] hold_ch;
  logic [31:0] hold_rate;
  logic [15:0] hold_bits;
  logic        done;

  whp_pkg::out_beat_t header_q[$];
  whp_pkg::out_beat_t want;
  logic               has_res;
  whp_pkg::status_e   res_st;
  int                 mismatches = 0;

  assign errors_o = mismatches;

  task automatic clear_parse();
    ph        = whp_pkg::PH_RIFF_TAG;
    pos       = '0;
    fcnt      = '0;
    tag_sh    = '0;
    size_sh   = '0;
    skip_left = '0;
    fmt_found = 1'b0;
    hold_ch   = '0;
    hold_rate = '0;
    hold_bits = '0;
    done      = 1'b0;
  endtask

  task automatic parse_byte(input whp_pkg::in_beat_t b, output logic hit,
                            output whp_pkg::status_e st);
    logic [7:0] d;
    d   = b.data_byte;
    hit = 1'b0;
    st  = whp_pkg::ST_OK;
    if (b.first) clear_parse();
    if (!done) begin
      if (pos != '1) pos = pos + 32'd1;
      unique case (ph)
        whp_pkg::PH_RIFF_TAG, whp_pkg::PH_WAVE_TAG: begin
          tag_sh = {tag_sh[23:0], d};
          fcnt   = fcnt + 4'd1;
          if (fcnt == 4'd4) begin
            if (tag_sh != ((ph == whp_pkg::PH_RIFF_TAG) ? whp_pkg::TagRiff
                                                        : whp_pkg::TagWave)) begin
              hit = 1'b1;
              st  = whp_pkg::ST_BAD_TAG;
            end else begin
              fcnt = '0;
              ph   = (ph == whp_pkg::PH_RIFF_TAG) ? whp_pkg::PH_RIFF_SIZE
                                                  : whp_pkg::PH_CHUNK_HDR;
            end
          end
        end
        whp_pkg::PH_RIFF_SIZE: begin
          fcnt = fcnt + 4'd1;
          if (fcnt == 4'd4) begin
            fcnt = '0;
            ph   = whp_pkg::PH_WAVE_TAG;
          end
        end
        whp_pkg::PH_CHUNK_HDR: begin
          if (fcnt < 4'd4) tag_sh = {tag_sh[23:0], d};
          else size_sh = {d, size_sh[31:8]};
          fcnt = fcnt + 4'd1;
          if (fcnt == 4'd8) begin
            fcnt = '0;
            if (tag_sh == whp_pkg::TagFmt) begin
              if (size_sh < whp_pkg::FmtMin) begin
                hit = 1'b1;
                st  = whp_pkg::ST_FMT_SMALL;
              end else begin
                ph = whp_pkg::PH_FMT_BODY;
              end
            end else if (tag_sh == whp_pkg::TagData) begin
              hit = 1'b1;
              st  = fmt_found ? whp_pkg::ST_OK : whp_pkg::ST_NO_FMT;
            end else if (size_sh != '0) begin
              skip_left = size_sh;
              ph        = whp_pkg::PH_SKIP;
            end
          end
        end
        whp_pkg::PH_FMT_BODY: begin
          unique case (fcnt)
            4'd2:  hold_ch = {8'h00, d};
            4'd3:  hold_ch[15:8] = d;
            4'd4:  hold_rate = {24'h0, d};
            4'd5:  hold_rate[15:8] = d;
            4'd6:  hold_rate[23:16] = d;
            4'd7:  hold_rate[31:24] = d;
            4'd14: hold_bits = {8'h00, d};
            4'd15: hold_bits[15:8] = d;
            default: ;
          endcase
          fcnt = fcnt + 4'd1;
          if (fcnt == 4'd0) begin
            fmt_found = 1'b1;
            skip_left = size_sh - whp_pkg::FmtMin;
            ph        = (skip_left == '0) ? whp_pkg::PH_CHUNK_HDR : whp_pkg::PH_SKIP;
          end
        end
        whp_pkg::PH_SKIP: begin
          if (skip_left != '0) skip_left = skip_left - 32'd1;
          if (skip_left == '0) begin
            ph   = whp_pkg::PH_CHUNK_HDR;
            fcnt = '0;
          end
        end
        default: ;
      endcase
      if (!hit && b.last) begin
        hit = 1'b1;
        st  = whp_pkg::ST_TRUNC;
      end
      if (hit) begin
        done = 1'b1;
        ph   = whp_pkg::PH_DONE;
      end
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, fname, exp_val, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      header_q.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (header_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with none expected, status %0d", $realtime,
                     out_beat_i.status);
        end else begin
          want = header_q.pop_front();
          check_field("status", 32'(out_beat_i.status), 32'(want.status));
          check_field("channels", 32'(out_beat_i.channels), 32'(want.channels));
          check_field("samp_rate", out_beat_i.samp_rate, want.samp_rate);
          check_field("sample_bits", 32'(out_beat_i.sample_bits), 32'(want.sample_bits));
          check_field("payload_size", out_beat_i.payload_size, want.payload_size);
          check_field("payload_offset", out_beat_i.payload_offset, want.payload_offset);
        end
      end
      if (in_valid_i && in_ready_i) begin
        parse_byte(in_beat_i, has_res, res_st);
        if (has_res) begin
          want        = '0;
          want.status = res_st;
          if (res_st == whp_pkg::ST_OK) begin
            want.channels       = hold_ch;
            want.samp_rate      = hold_rate;
            want.sample_bits    = hold_bits;
            want.payload_size   = size_sh;
            want.payload_offset = pos;
          end
          header_q.push_back(want);
        end
      end
      outstanding_o <= header_q.size();
    end
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int HoldCycles = 150;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  whp_pkg::in_beat_t  in_beat_i;
  logic               out_valid_o;
  logic               out_ready_i;
  whp_pkg::out_beat_t out_beat_o;

  int          errors;
  int          outstanding;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  logic        hold_req  = 1'b0;
  int          items     = 0;
  int          files     = 0;
  int          live_len  = -1;
  logic [7:0]  file_bytes[$];

  wave_header_parser u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_beat_i,
    .out_valid_o,
    .out_ready_i,
    .out_beat_o
  );

  wave_header_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i    (in_ready_o),
    .in_beat_i,
    .out_valid_i   (out_valid_o),
    .out_ready_i,
    .out_beat_i    (out_beat_o),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("wave_header_parser test failed");
    $finish;
  end

  // hold off for a long stretch on request, else stall at random
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [31:0] pick32();
    unique case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_tag();
    logic [31:0] t;
    t = $urandom();
    if (t == whp_pkg::TagFmt || t == whp_pkg::TagData) t = t ^ 32'h1;
    return t;
  endfunction

  task automatic new_file();
    file_bytes.delete();
    live_len = -1;
  endtask

  task automatic add_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(t[8*i +: 8]);
  endtask

  task automatic add_le16(input logic [15:0] v);
    file_bytes.push_back(v[7:0]);
    file_bytes.push_back(v[15:8]);
  endtask

  task automatic add_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) file_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic add_rand(input int n);
    repeat (n) file_bytes.push_back(8'($urandom()));
  endtask

  task automatic add_head();
    add_tag(whp_pkg::TagRiff);
    add_le32($urandom());
    add_tag(whp_pkg::TagWave);
  endtask

  task automatic add_chunk(input logic [31:0] t, input logic [31:0] sz);
    add_tag(t);
    add_le32(sz);
    add_rand(sz);
  endtask

  task automatic add_fmt(input logic [31:0] sz, input logic [15:0] ch,
                         input logic [31:0] rate, input logic [15:0] bits);
    add_tag(whp_pkg::TagFmt);
    add_le32(sz);
    if (sz >= whp_pkg::FmtMin) begin
      add_le16(16'($urandom()));
      add_le16(ch);
      add_le32(rate);
      add_le32($urandom());
      add_le16(16'($urandom()));
      add_le16(bits);
      add_rand(sz - whp_pkg::FmtMin);
    end
  endtask

  task automatic add_data(input logic [31:0] sz);
    add_tag(whp_pkg::TagData);
    add_le32(sz);
    live_len = file_bytes.size();
  endtask

  task automatic cut_file(input int n);
    while (file_bytes.size() > n) void'(file_bytes.pop_back());
    live_len = n;
  endtask

  task automatic build_good();
    new_file();
    add_head();
    repeat ($urandom_range(0, 2)) add_chunk(rand_tag(), $urandom_range(0, 6));
    add_fmt(($urandom_range(0, 3) == 0) ? 16 + $urandom_range(1, 5) : 16,
            16'(pick32()), pick32(), 16'(pick32()));
    if ($urandom_range(0, 9) == 0) add_fmt(16, 16'(pick32()), pick32(), 16'(pick32()));
    if ($urandom_range(0, 3) == 0) add_chunk(rand_tag(), $urandom_range(0, 4));
    add_data(pick32());
    add_rand($urandom_range(0, 3));
  endtask

  task automatic send_byte(input whp_pkg::in_beat_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_file(input logic mark_first, input logic mark_last);
    whp_pkg::in_beat_t b;
    int                lim;
    lim = (live_len < 0) ? file_bytes.size() : live_len;
    for (int i = 0; i < file_bytes.size(); i++) begin
      b.data_byte = file_bytes[i];
      b.first     = mark_first && (i == 0);
      b.last      = mark_last && (i == file_bytes.size() - 1);
      send_byte(b);
      if (i < lim) items++;
    end
    files++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_file();
    int r;
    int idx;
    r = $urandom_range(99);
    if (r < 65) begin
      build_good();
      send_file(1'b1, $urandom_range(0, 9) != 0);
    end else if (r < 70) begin
      build_good();
      idx = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(8, 11);
      file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
      live_len = idx + 1;
      send_file(1'b1, 1'b1);
    end else if (r < 75) begin
      new_file();
      add_head();
      if ($urandom_range(0, 1)) add_chunk(rand_tag(), $urandom_range(0, 4));
      add_fmt($urandom_range(0, 15), '0, '0, '0);
      live_len = file_bytes.size();
      add_rand($urandom_range(0, 3));
      send_file(1'b1, 1'b1);
    end else if (r < 80) begin
      new_file();
      add_head();
      if ($urandom_range(0, 1)) add_chunk(rand_tag(), $urandom_range(0, 4));
      add_data(pick32());
      send_file(1'b1, 1'b1);
    end else if (r < 88) begin
      build_good();
      cut_file($urandom_range(1, live_len));
      send_file(1'b1, 1'b1);
    end else if (r < 93) begin
      new_file();
      add_head();
      add_tag(rand_tag());
      add_le32($urandom() | 32'h0100_0000);
      add_rand($urandom_range(0, 6));
      send_file(1'b1, 1'b1);
    end else begin
      new_file();
      add_rand($urandom_range(1, 12));
      send_file(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_beat_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // good file with no first mark, all-ones fields
    new_file();
    add_head();
    add_fmt(16, '1, '1, '1);
    add_data('1);
    add_rand(2);
    send_file(1'b0, 1'b1);

    // all-zero fields, zero-size chunk, fmt with extra bytes, data on the last byte
    new_file();
    add_head();
    add_chunk(rand_tag(), 0);
    add_fmt(18, '0, '0, '0);
    add_data('0);
    send_file(1'b1, 1'b1);

    // bad RIFF tag
    new_file();
    add_tag(whp_pkg::TagRiff ^ 32'h0000_0080);
    send_file(1'b1, 1'b0);

    // bad WAVE tag
    new_file();
    add_tag(whp_pkg::TagRiff);
    add_le32('1);
    add_tag(whp_pkg::TagWave ^ 32'h8000_0000);
    send_file(1'b1, 1'b0);

    // fmt one byte short of minimum
    new_file();
    add_head();
    add_fmt(15, '0, '0, '0);
    send_file(1'b1, 1'b0);

    // data before fmt
    new_file();
    add_head();
    add_data(32'h1234_5678);
    send_file(1'b1, 1'b0);

    // repeated fmt, stream left open
    new_file();
    add_head();
    add_fmt(16, 16'h0001, 32'd8000, 16'd8);
    add_fmt(20, 16'h0002, 32'd44100, 16'd16);
    add_data(32'h0000_1000);
    send_file(1'b1, 1'b0);

    // stream ends inside a skip
    new_file();
    add_head();
    add_chunk(rand_tag(), 10);
    cut_file(25);
    send_file(1'b1, 1'b1);

    // stream ends exactly at end of a chunk
    new_file();
    add_head();
    add_fmt(16, 16'h0002, 32'd48000, 16'd24);
    send_file(1'b1, 1'b1);

    // single byte file
    new_file();
    add_rand(1);
    send_file(1'b1, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      unique case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 67; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      if (p == 2) begin
        hold_req = 1'b1;
        repeat (4) begin
          new_file();
          add_tag(rand_tag());
          send_file(1'b1, 1'b0);
        end
        drain();
      end
      while (items < (p + 1) * 450 || (p == 3 && files < 60)) random_file();
      drain();
    end

    $display("Covered %0d files, %0d parsed bytes, with directed error and truncation cases,",
             files, items);
    $display("four idle/stall mixes, a long result hold-off and full drains.");
    if (errors == 0 && outstanding == 0) begin
      $display("wave_header_parser test passed");
    end else begin
      $display("wave_header_parser test failed");
    end
    $finish;
  end

endmodule
